[rtl/core/mexp_pkg.sv]
package mexp_pkg;

    localparam int MOD_WIDTH  = 32;
    localparam int BASE_WIDTH = 63;
    localparam int EXP_WIDTH  = 63;
    localparam int OUT_WIDTH  = 32;

    // multiplier operand scanned msb first; wide enough for the base reduction
    localparam int OPX_WIDTH  = BASE_WIDTH;
    localparam int CNT_WIDTH  = $clog2(OPX_WIDTH + 1);

    localparam int IN_BYTES   = (BASE_WIDTH + EXP_WIDTH + 7) / 8;
    localparam int IN_TDATA_W = IN_BYTES * 8;
    localparam int OUT_BYTES  = (OUT_WIDTH + 7) / 8;
    localparam int OUT_TDATA_W = OUT_BYTES * 8;

    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;
    localparam int REG_IDX_W  = 1;

    localparam logic [REG_IDX_W-1:0] REG_MODULUS = 1'b0;

    typedef enum logic [5:0] {
        ST_IDLE   = 6'b000001,
        ST_REDUCE = 6'b000010,
        ST_CHECK  = 6'b000100,
        ST_MUL    = 6'b001000,
        ST_SQR    = 6'b010000,
        ST_DONE   = 6'b100000
    } mexp_state_t;

    typedef struct packed {
        logic                 start;
        logic [CNT_WIDTH-1:0] nbits;
        logic [OPX_WIDTH-1:0] x;
        logic [MOD_WIDTH-1:0] y;
    } mm_req_t;

    typedef struct packed {
        logic                 done;
        logic [MOD_WIDTH-1:0] value;
    } mm_rsp_t;

endpackage

[rtl/core/mexp_mulmod.sv]
module mexp_mulmod (
    input  logic                          clk,
    input  logic                          rst_n,
    input  mexp_pkg::mm_req_t             req,
    input  logic [mexp_pkg::MOD_WIDTH-1:0] modulus,
    output mexp_pkg::mm_rsp_t             rsp
);
    import mexp_pkg::*;

    logic                 busy_reg;
    logic                 done_reg;
    logic [CNT_WIDTH-1:0] cnt_reg;
    logic [OPX_WIDTH-1:0] x_reg;
    logic [MOD_WIDTH-1:0] y_reg;
    logic [MOD_WIDTH-1:0] r_reg;

    logic [MOD_WIDTH:0]   dbl;
    logic [MOD_WIDTH:0]   dbl_red;
    logic [MOD_WIDTH:0]   sum;
    logic [MOD_WIDTH:0]   sum_red;
    logic [MOD_WIDTH-1:0] addend;
    logic [MOD_WIDTH:0]   m_ext;

    // one step of r = (2r + bit*y) mod m, with r < m and y <= m
    always_comb
    begin
        m_ext   = {1'b0, modulus};
        dbl     = {r_reg, 1'b0};
        dbl_red = (dbl >= m_ext) ? (dbl - m_ext) : dbl;
        addend  = x_reg[OPX_WIDTH-1] ? y_reg : '0;
        sum     = {1'b0, dbl_red[MOD_WIDTH-1:0]} + {1'b0, addend};
        sum_red = (sum >= m_ext) ? (sum - m_ext) : sum;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= req.nbits;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - CNT_WIDTH'(1);
                if (cnt_reg == CNT_WIDTH'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            x_reg <= req.x;
            y_reg <= req.y;
            r_reg <= '0;
        end
        else if (busy_reg)
        begin
            x_reg <= {x_reg[OPX_WIDTH-2:0], 1'b0};
            r_reg <= sum_red[MOD_WIDTH-1:0];
        end
    end

    assign rsp.done  = done_reg;
    assign rsp.value = r_reg;

endmodule

[rtl/core/modular_exponentiation_unit.sv]
// Modular exponentiation: power_result = base_value ** exponent mod modulus, right-to-left
// square-and-multiply. The base is first reduced by a 63-step shift-subtract pass, then each
// exponent bit costs one modular squaring plus one modular multiply when the bit is set; every
// modular product goes through a single shared 32-step shift-add multiplier.
// s_tready is low while an item is in progress. A zero exponent returns 1 for any modulus;
// a modulus of 0 acts as 1. The modulus register (reset 1) sits at address 0 and must only
// be written while the block is idle.
module modular_exponentiation_unit (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // [62:0] base_value, [125:63] exponent, [127:126] zero
    input  logic [mexp_pkg::IN_TDATA_W-1:0]     s_tdata,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // [31:0] power_result
    output logic [mexp_pkg::OUT_TDATA_W-1:0]    m_tdata,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [mexp_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [mexp_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [mexp_pkg::APB_DATA_W-1:0]     prdata,
    output logic                                pready
);
    import mexp_pkg::*;

    mexp_state_t          state_reg, state_next;
    logic                 launch_reg, launch_next;
    logic [MOD_WIDTH-1:0] modulus_reg;
    logic [MOD_WIDTH-1:0] m_eff;
    logic [MOD_WIDTH-1:0] b_reg;
    logic [EXP_WIDTH-1:0] e_reg;
    logic [MOD_WIDTH-1:0] acc_reg;
    logic                 out_valid_reg;
    logic [OUT_WIDTH-1:0] out_data_reg;
    logic [REG_IDX_W-1:0] reg_idx;
    logic                 cfg_write;
    logic                 accept;
    logic                 out_load;
    // reduce pass keeps the full base in a separate register until it completes
    logic [BASE_WIDTH-1:0] base_reg;

    mm_req_t mm_req;
    mm_rsp_t mm_rsp;

    assign reg_idx   = paddr[APB_ADDR_W-1:2];
    assign cfg_write = psel && penable && pwrite;
    assign pready    = 1'b1;
    assign prdata    = (reg_idx == REG_MODULUS) ? APB_DATA_W'(modulus_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            modulus_reg <= MOD_WIDTH'(1);
        end
        else if (cfg_write && reg_idx == REG_MODULUS)
        begin
            modulus_reg <= pwdata[MOD_WIDTH-1:0];
        end
    end

    assign m_eff    = (modulus_reg == '0) ? MOD_WIDTH'(1) : modulus_reg;
    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign out_load = (state_reg == ST_DONE) && (!out_valid_reg || m_tready);

    always_comb
    begin
        mm_req.start = launch_reg;
        case (state_reg)
            ST_REDUCE:
            begin
                mm_req.nbits = CNT_WIDTH'(BASE_WIDTH);
                mm_req.x     = base_reg;
                mm_req.y     = MOD_WIDTH'(1);
            end
            ST_MUL:
            begin
                mm_req.nbits = CNT_WIDTH'(MOD_WIDTH);
                mm_req.x     = {acc_reg, {(OPX_WIDTH-MOD_WIDTH){1'b0}}};
                mm_req.y     = b_reg;
            end
            default:
            begin
                mm_req.nbits = CNT_WIDTH'(MOD_WIDTH);
                mm_req.x     = {b_reg, {(OPX_WIDTH-MOD_WIDTH){1'b0}}};
                mm_req.y     = b_reg;
            end
        endcase
    end

    mexp_mulmod u_mulmod (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (mm_req),
        .modulus (m_eff),
        .rsp     (mm_rsp)
    );

    always_comb
    begin
        state_next  = state_reg;
        launch_next = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next  = ST_REDUCE;
                    launch_next = 1'b1;
                end
            end
            ST_REDUCE:
            begin
                if (mm_rsp.done)
                begin
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                if (e_reg == '0)
                begin
                    state_next = ST_DONE;
                end
                else if (e_reg[0])
                begin
                    state_next  = ST_MUL;
                    launch_next = 1'b1;
                end
                else
                begin
                    state_next  = ST_SQR;
                    launch_next = 1'b1;
                end
            end
            ST_MUL:
            begin
                if (mm_rsp.done)
                begin
                    state_next  = ST_SQR;
                    launch_next = 1'b1;
                end
            end
            ST_SQR:
            begin
                if (mm_rsp.done)
                begin
                    state_next = ST_CHECK;
                end
            end
            ST_DONE:
            begin
                if (out_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            launch_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            launch_reg <= launch_next;
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            base_reg <= s_tdata[BASE_WIDTH-1:0];
            e_reg    <= s_tdata[BASE_WIDTH+EXP_WIDTH-1:BASE_WIDTH];
            acc_reg  <= MOD_WIDTH'(1);
        end
        else if (mm_rsp.done)
        begin
            case (state_reg)
                ST_REDUCE:
                begin
                    b_reg <= mm_rsp.value;
                end
                ST_MUL:
                begin
                    acc_reg <= mm_rsp.value;
                end
                ST_SQR:
                begin
                    b_reg <= mm_rsp.value;
                    e_reg <= e_reg >> 1;
                end
                default:
                begin
                    b_reg <= b_reg;
                end
            endcase
        end
        if (out_load)
        begin
            out_data_reg <= OUT_WIDTH'(acc_reg);
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = OUT_TDATA_W'(out_data_reg);

endmodule
